@@ rtl/core/slpl_pkg.sv @@
// shared constants and types for the slab point location bin counter
`timescale 1ns / 1ps

package slpl_pkg;

  localparam int KIND_W      = 2;
  localparam int SLOT_W      = 12;
  localparam int BIN_W       = 12;
  localparam int COUNT_OUT_W = 16;
  localparam int PCOUNT_W    = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int OUT_DATA_W  = ((BIN_W + COUNT_OUT_W + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_WRITE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOCATE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR_READ = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_BOX_LEFT_X    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOX_TOP_Y     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOX_RIGHT_X   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOX_BOTTOM_Y  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARTITION_CNT = 3'd4;

  typedef struct packed {
    logic valid;
    logic pos;
    logic neg;
  } side_t;

endpackage

@@ rtl/core/slpl_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module slpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/slpl_cross.sv @@
// two stage cross product sign unit: differences, then products, then compare
`timescale 1ns / 1ps

module slpl_cross
  import slpl_pkg::*;
#(
  parameter int COORD_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] xb,
  input  logic signed [COORD_BITS-1:0] xt,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] yb,
  input  logic signed [COORD_BITS-1:0] yt,
  output side_t                        side
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic              v1;
  logic              v2;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] qx;
  logic signed [DW-1:0] qy;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dx <= DW'(xt) - DW'(xb);
    dy <= DW'(yt) - DW'(yb);
    qx <= DW'(px) - DW'(xb);
    qy <= DW'(py) - DW'(yb);
    p1 <= PW'(qx) * PW'(dy);
    p2 <= PW'(qy) * PW'(dx);
  end

  assign side.valid = v2;
  assign side.pos   = (p1 > p2);
  assign side.neg   = (p1 < p2);

endmodule

@@ rtl/core/slab_point_location_bin_counter.sv @@
// top level: slab point location with per bin hit counters
`timescale 1ns / 1ps

// Kind 0 stores a partition; kind 2 reads and clears a bin count; kind 1 locates a
// point by a binary search over the segments, each search step going through the
// segment memory read, the difference stage and the product stage, whose sign
// decision issues the next read; a found bin then gets a read-modify-write of the
// bin count memory. One item is in work at a time; a finished result waits in the
// output register. After reset the bin counters are cleared one per cycle, and no
// item is accepted until then; configuration writes are taken at any time.

module slab_point_location_bin_counter
  import slpl_pkg::*;
#(
  parameter int MAX_PARTITIONS = 4095,
  parameter int COORD_BITS     = 18,
  parameter int COUNT_BITS     = 16
) (
  input  logic clk,
  input  logic rst,

  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // slot, top_x, bottom_x, point_x, point_y
  input  logic [((SLOT_W + 4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // kind
  input  logic [KIND_W-1:0]                             s_axis_tuser,

  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // bin, count
  output logic [OUT_DATA_W-1:0]                         m_axis_tdata,

  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]                        cfg_index,
  input  logic [((COORD_BITS > PCOUNT_W) ? COORD_BITS : PCOUNT_W)-1:0] cfg_data
);

  localparam int IW        = $clog2(MAX_PARTITIONS + 2);
  localparam int CW        = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int SEG_AW    = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int BIN_DEPTH = MAX_PARTITIONS + 1;
  localparam int BIN_AW    = $clog2(BIN_DEPTH);
  localparam int CXW       = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_BIN    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [BIN_AW-1:0] clr_addr;

  logic signed [COORD_BITS-1:0] left_x;
  logic signed [COORD_BITS-1:0] top_y;
  logic signed [COORD_BITS-1:0] right_x;
  logic signed [COORD_BITS-1:0] bottom_y;
  logic [PCOUNT_W-1:0]          pcount;

  logic [KIND_W-1:0]            kind_r;
  logic [SLOT_W-1:0]            slot_r;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;

  logic [IW-1:0] front;
  logic [IW-1:0] rear;
  logic [IW-1:0] mid;
  logic [IW-1:0] found_r;
  logic          front_pos;
  logic          init;
  logic          step_go;
  logic          sel_left;
  logic          sel_right;
  logic [BIN_AW-1:0] bin_addr;

  logic [BIN_W-1:0]       res_bin;
  logic [COUNT_OUT_W-1:0] res_cnt;
  logic                   out_valid;
  logic [BIN_W-1:0]       out_bin;
  logic [COUNT_OUT_W-1:0] out_cnt;

  // input unpack
  logic                         accept;
  logic [SLOT_W-1:0]            in_slot;
  logic [CW-1:0]                in_slot_w;
  logic signed [COORD_BITS-1:0] in_top_x;
  logic signed [COORD_BITS-1:0] in_bottom_x;
  logic signed [COORD_BITS-1:0] in_point_x;
  logic signed [COORD_BITS-1:0] in_point_y;

  logic [IW-1:0] n_eff;

  // search decision
  side_t         side;
  logic [IW-1:0] front_n;
  logic [IW-1:0] rear_n;
  logic          fpos_n;
  logic          done;
  logic [IW-1:0] found;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid_next;
  logic          left_next;
  logic          right_next;

  // memories
  logic                        seg_we;
  logic [SEG_AW-1:0]           seg_waddr;
  logic [SEG_AW-1:0]           seg_raddr;
  logic [2*COORD_BITS-1:0]     seg_wdata;
  logic [2*COORD_BITS-1:0]     seg_rdata;
  logic signed [COORD_BITS-1:0] xb_sel;
  logic signed [COORD_BITS-1:0] xt_sel;

  logic                  bin_we;
  logic [BIN_AW-1:0]     bin_waddr;
  logic [BIN_AW-1:0]     bin_raddr;
  logic [COUNT_BITS-1:0] bin_wdata;
  logic [COUNT_BITS-1:0] bin_rdata;
  logic [COUNT_BITS-1:0] bin_inc;
  logic [CXW-1:0]        cnt_ext;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'({out_cnt, out_bin});

  assign in_slot     = s_axis_tdata[SLOT_W-1:0];
  assign in_slot_w   = CW'(in_slot);
  assign in_top_x    = s_axis_tdata[SLOT_W +: COORD_BITS];
  assign in_bottom_x = s_axis_tdata[SLOT_W + COORD_BITS +: COORD_BITS];
  assign in_point_x  = s_axis_tdata[SLOT_W + 2 * COORD_BITS +: COORD_BITS];
  assign in_point_y  = s_axis_tdata[SLOT_W + 3 * COORD_BITS +: COORD_BITS];

  assign n_eff = (CW'(pcount) > CW'(MAX_PARTITIONS)) ? IW'(MAX_PARTITIONS) : IW'(pcount);

  always_comb begin
    front_n = front;
    rear_n  = rear;
    fpos_n  = front_pos;
    done    = 1'b0;
    found   = mid;
    if (init) begin
      fpos_n = side.pos;
    end else if (front_pos && side.neg) begin
      if (mid == front + IW'(1)) begin
        done  = 1'b1;
        found = front;
      end else begin
        rear_n = mid;
      end
    end else begin
      if (mid + IW'(1) == rear) begin
        done  = 1'b1;
        found = mid;
      end else begin
        front_n = mid;
        fpos_n  = side.pos;
      end
    end
    mid_sum    = {1'b0, front_n} + {1'b0, rear_n};
    mid_next   = mid_sum[IW:1];
    left_next  = (mid_next == '0);
    right_next = (mid_next >= n_eff + IW'(1));
    seg_raddr  = SEG_AW'(mid_next - IW'(1));
  end

  // segment memory: {top_x, bottom_x}
  assign seg_we    = accept && (s_axis_tuser == KIND_WRITE) &&
                     (in_slot_w < CW'(MAX_PARTITIONS));
  assign seg_waddr = SEG_AW'(in_slot_w);
  assign seg_wdata = {in_top_x, in_bottom_x};

  slpl_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_PARTITIONS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_rdata)
  );

  always_comb begin
    if (sel_left) begin
      xb_sel = left_x;
      xt_sel = left_x;
    end else if (sel_right) begin
      xb_sel = right_x;
      xt_sel = right_x;
    end else begin
      xb_sel = seg_rdata[COORD_BITS-1:0];
      xt_sel = seg_rdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

  slpl_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk   (clk),
    .rst   (rst),
    .start (step_go),
    .xb    (xb_sel),
    .xt    (xt_sel),
    .px    (px),
    .py    (py),
    .yb    (bottom_y),
    .yt    (top_y),
    .side  (side)
  );

  // bin count memory
  assign bin_raddr = (state == S_IDLE) ? BIN_AW'(in_slot_w) : BIN_AW'(found);
  assign bin_inc   = (bin_rdata == {COUNT_BITS{1'b1}}) ? bin_rdata
                                                      : bin_rdata + COUNT_BITS'(1);
  assign cnt_ext   = CXW'(bin_rdata);

  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = bin_addr;
    bin_wdata = '0;
    if (state == S_CLEAR) begin
      bin_we    = 1'b1;
      bin_waddr = clr_addr;
    end else if (state == S_BIN) begin
      bin_we = 1'b1;
      if (kind_r == KIND_LOCATE) begin
        bin_wdata = bin_inc;
      end
    end
  end

  slpl_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_DEPTH)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      step_go   <= 1'b0;
      left_x    <= '0;
      top_y     <= '0;
      right_x   <= '0;
      bottom_y  <= '0;
      pcount    <= '0;
    end else begin
      step_go <= 1'b0;
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BOX_LEFT_X:    left_x   <= cfg_data[COORD_BITS-1:0];
          CFG_BOX_TOP_Y:     top_y    <= cfg_data[COORD_BITS-1:0];
          CFG_BOX_RIGHT_X:   right_x  <= cfg_data[COORD_BITS-1:0];
          CFG_BOX_BOTTOM_Y:  bottom_y <= cfg_data[COORD_BITS-1:0];
          CFG_PARTITION_CNT: pcount   <= cfg_data[PCOUNT_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == BIN_AW'(MAX_PARTITIONS)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + BIN_AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (s_axis_tuser)
              KIND_LOCATE: begin
                state   <= S_SEARCH;
                step_go <= 1'b1;
              end
              KIND_CLEAR_READ: begin
                if (in_slot_w <= CW'(MAX_PARTITIONS)) begin
                  state <= S_BIN;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SEARCH: begin
          if (side.valid) begin
            if (done) begin
              state <= S_BIN;
            end else begin
              step_go <= 1'b1;
            end
          end
        end
        S_BIN: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= s_axis_tuser;
      slot_r    <= in_slot;
      px        <= in_point_x;
      py        <= in_point_y;
      res_bin   <= in_slot;
      res_cnt   <= '0;
      front     <= '0;
      rear      <= n_eff + IW'(1);
      init      <= 1'b1;
      sel_left  <= 1'b1;
      sel_right <= 1'b0;
      bin_addr  <= bin_raddr;
    end
    if (state == S_SEARCH && side.valid) begin
      front     <= front_n;
      rear      <= rear_n;
      front_pos <= fpos_n;
      init      <= 1'b0;
      mid       <= mid_next;
      sel_left  <= left_next;
      sel_right <= right_next;
      if (done) begin
        found_r  <= found;
        bin_addr <= bin_raddr;
      end
    end
    if (state == S_BIN) begin
      if (kind_r == KIND_LOCATE) begin
        res_bin <= BIN_W'(found_r);
      end else begin
        res_bin <= slot_r;
        res_cnt <= cnt_ext[COUNT_OUT_W-1:0];
      end
    end
    if (state == S_DONE && (!out_valid || m_axis_tready)) begin
      out_bin <= res_bin;
      out_cnt <= res_cnt;
    end
  end

endmodule

@@ verif/tb.sv @@
// testbench for the slab point location bin counter: random and directed traffic with a scoreboard
`timescale 1ns / 1ps

module tb;
  import slpl_pkg::*;

  localparam int COORD_W     = 18;
  localparam int CNT_W       = 16;
  localparam int MAX_PARTS   = 4095;
  localparam int IN_W        = ((SLOT_W + 4 * COORD_W + 7) / 8) * 8;
  localparam int CFG_W       = (COORD_W > PCOUNT_W) ? COORD_W : PCOUNT_W;
  localparam int COORD_MIN   = -(1 << (COORD_W - 1));
  localparam int COORD_MAX   = (1 << (COORD_W - 1)) - 1;
  localparam int SAT_HITS    = (1 << CNT_W) + 1;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 190;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 64;
  localparam longint CYCLE_LIMIT = 10_000_000;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef enum {PACE_FULL, PACE_RANDOM, PACE_PATTERN} pace_e;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] top_x;
    logic signed [COORD_W-1:0] bottom_x;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } req_t;

  typedef struct {
    logic [BIN_W-1:0]       bin;
    logic [COUNT_OUT_W-1:0] count;
  } res_t;

  class bin_scoreboard;
    logic signed [COORD_W-1:0] left_x, top_y, right_x, bottom_y;
    logic [PCOUNT_W-1:0]       parts;
    logic signed [COORD_W-1:0] seg_top[MAX_PARTS];
    logic signed [COORD_W-1:0] seg_bot[MAX_PARTS];
    logic [CNT_W-1:0]          hits[MAX_PARTS + 1];
    bit                        written[MAX_PARTS];
    res_t                      expected_q[$];
    int                        errors, checked, accepted, located;

    function new();
      left_x = 0; top_y = 0; right_x = 0; bottom_y = 0; parts = 0;
      errors = 0; checked = 0; accepted = 0; located = 0;
      for (int i = 0; i <= MAX_PARTS; i++) hits[i] = 0;
      for (int i = 0; i < MAX_PARTS; i++) begin
        seg_top[i] = 0;
        seg_bot[i] = 0;
        written[i] = 0;
      end
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_BOX_LEFT_X:    left_x = data[COORD_W-1:0];
        CFG_BOX_TOP_Y:     top_y = data[COORD_W-1:0];
        CFG_BOX_RIGHT_X:   right_x = data[COORD_W-1:0];
        CFG_BOX_BOTTOM_Y:  bottom_y = data[COORD_W-1:0];
        CFG_PARTITION_CNT: parts = data[PCOUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // sign of (p - lower end) x (upper end - lower end) for segment s
    function int side_of(int unsigned s, int unsigned n, longint px, longint py);
      longint xb, xt, c;
      if (s == 0) begin
        xb = left_x;
        xt = left_x;
      end else if (s >= n + 1) begin
        xb = right_x;
        xt = right_x;
      end else begin
        xb = seg_bot[s - 1];
        xt = seg_top[s - 1];
      end
      c = (px - xb) * (longint'(top_y) - longint'(bottom_y))
          - (py - longint'(bottom_y)) * (xt - xb);
      if (c > 0) return 1;
      if (c < 0) return -1;
      return 0;
    endfunction

    function int unsigned find_bin(longint px, longint py);
      int unsigned n, front, rear, mid;
      n = parts;
      if (n > MAX_PARTS) n = MAX_PARTS;
      front = 0;
      rear = n + 1;
      while (front < rear) begin
        mid = (front + rear) >> 1;
        if (side_of(front, n, px, py) > 0 && side_of(mid, n, px, py) < 0) begin
          if (mid == front + 1) return front;
          rear = mid;
        end else begin
          if (mid + 1 == rear) return mid;
          front = mid;
        end
      end
      return front;
    endfunction

    function void note_input(req_t it);
      res_t        r;
      int unsigned b;
      accepted++;
      r.bin = it.slot;
      r.count = 0;
      case (it.kind)
        KIND_WRITE: begin
          if (it.slot < MAX_PARTS) begin
            seg_top[it.slot] = it.top_x;
            seg_bot[it.slot] = it.bottom_x;
            written[it.slot] = 1;
          end
        end
        KIND_LOCATE: begin
          b = find_bin(longint'(it.point_x), longint'(it.point_y));
          located++;
          if (b <= MAX_PARTS && hits[b] != '1) hits[b]++;
          r.bin = b[BIN_W-1:0];
        end
        KIND_CLEAR_READ: begin
          r.count = hits[it.slot];
          hits[it.slot] = 0;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [BIN_W-1:0] bin, logic [COUNT_OUT_W-1:0] count);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result bin %0d count %0d", $time, bin, count);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (bin !== e.bin) begin
        errors++;
        if (errors <= 40)
          $display("%0t: bin mismatch, expected %0d actual %0d", $time, e.bin, bin);
      end
      if (count !== e.count) begin
        errors++;
        if (errors <= 40)
          $display("%0t: count mismatch, expected %0d actual %0d", $time, e.count, count);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic [KIND_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  bin_scoreboard sb = new();
  pace_e         tx_pace = PACE_FULL;
  pace_e         rx_pace = PACE_FULL;
  int            burst_left = 0;
  int unsigned   rx_tick = 0;
  longint        cycles = 0;

  slab_point_location_bin_counter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d results outstanding", cycles,
               sb.expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_pace)
      PACE_FULL:   m_axis_tready <= 1'b1;
      PACE_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:     m_axis_tready <= (rx_tick % 13) < 8;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      sb.check_result(m_axis_tdata[BIN_W-1:0], m_axis_tdata[BIN_W+COUNT_OUT_W-1:BIN_W]);
  end

  function automatic logic signed [COORD_W-1:0] coord_between(int a, int b);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v[COORD_W-1:0];
  endfunction

  function automatic req_t noise_item();
    req_t it;
    it.kind = $urandom_range(0, 3);
    it.slot = $urandom;
    it.top_x = $urandom;
    it.bottom_x = $urandom;
    it.point_x = $urandom;
    it.point_y = $urandom;
    return it;
  endfunction

  function automatic req_t make_req(logic [KIND_W-1:0] kind, int slot, int top, int bottom,
                                    int px, int py);
    req_t it;
    it.kind = kind;
    it.slot = slot;
    it.top_x = top;
    it.bottom_x = bottom;
    it.point_x = px;
    it.point_y = py;
    return it;
  endfunction

  // partition s of n, spread evenly across the box with a small slant
  function automatic req_t partition_item(int unsigned s, int unsigned n);
    req_t   it;
    longint l, r, base, j;
    it = noise_item();
    l = sb.left_x;
    r = sb.right_x;
    base = l + (r - l) * longint'(s + 1) / longint'(n + 1);
    j = ((r > l) ? r - l : l - r) / (4 * longint'(n + 1)) + 1;
    it.kind = KIND_WRITE;
    it.slot = s;
    it.top_x = clamp_coord(base + longint'($urandom_range(0, int'(2 * j))) - j);
    it.bottom_x = clamp_coord(base + longint'($urandom_range(0, int'(2 * j))) - j);
    return it;
  endfunction

  function automatic req_t random_item(int unsigned n);
    req_t        it;
    int unsigned pick, top_bin;
    it = noise_item();
    pick = $urandom_range(0, 99);
    top_bin = (n + 1 > MAX_PARTS) ? MAX_PARTS : n + 1;
    if (pick < 55) begin
      it.kind = KIND_LOCATE;
      if ($urandom_range(0, 7) != 0) begin
        it.point_x = coord_between(sb.left_x, sb.right_x);
        it.point_y = coord_between(sb.bottom_y, sb.top_y);
      end
    end else if (pick < 70) begin
      if (n > 0 && $urandom_range(0, 2) != 0) it = partition_item($urandom_range(0, n - 1), n);
      it.kind = KIND_WRITE;
    end else if (pick < 93) begin
      it.kind = KIND_CLEAR_READ;
      if ($urandom_range(0, 3) != 0) it.slot = $urandom_range(0, top_bin);
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  task automatic send(input req_t it);
    if (tx_pace != PACE_FULL) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W - SLOT_W - 4 * COORD_W){1'b0}}, it.point_y, it.point_x,
                     it.bottom_x, it.top_x, it.slot};
    s_axis_tuser <= it.kind;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_input(it);
  endtask

  task automatic drain(input int settle);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic configure(input int l, input int t, input int r, input int b,
                           input int unsigned n);
    logic [CFG_INDEX_W-1:0] idx[5];
    logic [CFG_W-1:0]       val[5];
    idx = '{CFG_BOX_LEFT_X, CFG_BOX_TOP_Y, CFG_BOX_RIGHT_X, CFG_BOX_BOTTOM_Y, CFG_PARTITION_CNT};
    val = '{l[CFG_W-1:0], t[CFG_W-1:0], r[CFG_W-1:0], b[CFG_W-1:0], n[CFG_W-1:0]};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // every partition the search may touch gets written before any point is located
  task automatic lay_partitions(input int unsigned n, input bit redo);
    for (int unsigned s = 0; s < n; s++)
      if (redo || !sb.written[s]) send(partition_item(s, n));
  endtask

  task automatic random_phase(input int items);
    int          l, t, r, b, pick;
    int unsigned n;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      l = coord_between(COORD_MIN, 60000);
      r = coord_between(l + 16, COORD_MAX);
      b = coord_between(COORD_MIN, 60000);
      t = coord_between(b + 16, COORD_MAX);
    end else if (pick == 7) begin
      if ($urandom_range(0, 1)) begin
        l = COORD_MIN; r = COORD_MAX; b = COORD_MIN; t = COORD_MAX;
      end else begin
        l = COORD_MAX; r = COORD_MIN; b = COORD_MAX; t = COORD_MIN;
      end
    end else begin
      l = coord_between(COORD_MIN, COORD_MAX);
      r = coord_between(COORD_MIN, COORD_MAX);
      b = coord_between(COORD_MIN, COORD_MAX);
      t = coord_between(COORD_MIN, COORD_MAX);
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) n = $urandom_range(0, 3);
    else if (pick < 9) n = $urandom_range(4, 60);
    else n = $urandom_range(61, 400);
    tx_pace = pace_e'($urandom_range(0, 2));
    rx_pace = pace_e'($urandom_range(0, 2));
    drain(SETTLE);
    configure(l, t, r, b, n);
    lay_partitions(n, $urandom_range(0, 3) != 0);
    for (int i = 0; i < items; i++) send(random_item(n));
    drain(SETTLE);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: three partitions in a small box, walls, points on and off segments
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_PATTERN;
    configure(-1000, 1000, 1000, -1000, 3);
    send(make_req(KIND_WRITE, 0, -500, -600, 0, 0));
    send(make_req(KIND_WRITE, 1, 0, 0, 0, 0));
    send(make_req(KIND_WRITE, 2, 600, 400, 0, 0));
    send(make_req(KIND_WRITE, MAX_PARTS, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
    send(make_req(KIND_WRITE, MAX_PARTS - 1, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    send(make_req(KIND_LOCATE, 0, 0, 0, -800, 0));
    send(make_req(KIND_LOCATE, 0, 0, 0, -200, 0));
    send(make_req(KIND_LOCATE, 0, 0, 0, 300, 0));
    send(make_req(KIND_LOCATE, 0, 0, 0, 900, 0));
    send(make_req(KIND_LOCATE, 0, 0, 0, 0, 0));
    send(make_req(KIND_LOCATE, 0, 0, 0, -600, -1000));
    send(make_req(KIND_LOCATE, 0, 0, 0, COORD_MIN, COORD_MIN));
    send(make_req(KIND_LOCATE, 0, 0, 0, COORD_MAX, COORD_MAX));
    send(make_req(KIND_LOCATE, 0, 0, 0, COORD_MIN, COORD_MAX));
    send(make_req(KIND_LOCATE, 0, 0, 0, COORD_MAX, COORD_MIN));
    for (int s = 0; s <= 4; s++) send(make_req(KIND_CLEAR_READ, s, 0, 0, 0, 0));
    send(make_req(KIND_CLEAR_READ, MAX_PARTS, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send(make_req(KIND_UNUSED, MAX_PARTS, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send(make_req(KIND_UNUSED, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    drain(SETTLE);

    // full coordinate range with every partition in use
    tx_pace = PACE_FULL;
    rx_pace = PACE_RANDOM;
    configure(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, MAX_PARTS);
    lay_partitions(MAX_PARTS, 1'b1);
    tx_pace = PACE_RANDOM;
    for (int i = 0; i < 80; i++) send(random_item(MAX_PARTS));
    drain(SETTLE);

    // drive one bin past its counter limit, then read it back
    tx_pace = PACE_FULL;
    rx_pace = PACE_FULL;
    configure(-64, 64, 64, -64, 0);
    for (int i = 0; i < SAT_HITS; i++)
      send(make_req(KIND_LOCATE, i, 0, 0, coord_between(-64, 64), coord_between(-64, 64)));
    send(make_req(KIND_CLEAR_READ, 0, 0, 0, 0, 0));
    drain(SETTLE);

    for (int p = 0; p < RAND_PHASES; p++) random_phase(PHASE_ITEMS);

    drain(TAIL);
    $display("covered %0d transactions in, %0d results checked, %0d points located",
             sb.accepted, sb.checked, sb.located);
    $display("settings: small boxes, inverted and full range boxes, 0 to %0d partitions, %s",
             MAX_PARTS, "one counter held at its limit");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/slpl_pkg.sv
rtl/core/slpl_ram.sv
rtl/core/slpl_cross.sv
rtl/core/slab_point_location_bin_counter.sv
verif/tb.sv
